// ----- design/lslux_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lslux_pkg
// Shared constants, types and helpers for the auto-ranging lux converter.
// ----------------------------------------------------------------------------
package lslux_pkg;

  localparam int FRACTION_BITS = 8;

  localparam int CODE_W  = 16;
  localparam int LUX_W   = 16;
  localparam int STAGE_W = 2;
  localparam int LIMIT_W = 16;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 4;
  localparam int REG_IDX_W = 2;

  // code * 18 needs five more bits, the stage scale up to four
  localparam int CODE18_W    = CODE_W + 5;
  localparam int NUM_W       = CODE18_W + 4 + FRACTION_BITS;
  // top bits of the numerator stay below 625
  localparam int DIV1_TOP_W  = 9;
  localparam int DVD_W       = NUM_W - DIV1_TOP_W;
  localparam int RAW_W       = 15 + FRACTION_BITS;
  localparam int ACC_W       = 2 * RAW_W + 1;
  localparam int Q_W         = ACC_W - FRACTION_BITS;
  localparam int REM_W       = 14;
  localparam int CNT_W       = $clog2(DVD_W + 1);

  localparam logic [REM_W-1:0] DIV_RAW  = REM_W'(625);
  localparam logic [REM_W-1:0] DIV_LIN  = REM_W'(100);
  localparam logic [REM_W-1:0] DIV_QUAD = REM_W'(10000);

  localparam logic [RAW_W-1:0] K_LIN = RAW_W'(283);
  localparam logic [RAW_W-1:0] K_SQ  = RAW_W'(29);
  localparam logic [RAW_W-1:0] K_LT  = RAW_W'(22112);

  localparam logic [CNT_W-1:0] STEPS_RAW = CNT_W'(DVD_W);
  localparam logic [CNT_W-1:0] STEPS_LIN = CNT_W'(9);
  localparam logic [CNT_W-1:0] STEPS_SQ  = CNT_W'(RAW_W);
  localparam logic [CNT_W-1:0] STEPS_29  = CNT_W'(5);
  localparam logic [CNT_W-1:0] STEPS_LT  = CNT_W'(15);
  localparam logic [CNT_W-1:0] STEPS_LUX = CNT_W'(LUX_W);

  localparam logic [ACC_W-1:0] QUAD_BIAS = ACC_W'(185227) << FRACTION_BITS;

  localparam logic [STAGE_W-1:0] STAGE_X2      = 2'd0;
  localparam logic [STAGE_W-1:0] STAGE_X1      = 2'd1;
  localparam logic [STAGE_W-1:0] STAGE_QUARTER = 2'd2;
  localparam logic [STAGE_W-1:0] STAGE_EIGHTH  = 2'd3;

  localparam logic [REG_IDX_W-1:0] REG_LIMIT0 = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_LIMIT1 = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_LIMIT2 = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_LOW    = 2'd3;

  typedef struct packed {
    logic [LIMIT_W-1:0] limit0;
    logic [LIMIT_W-1:0] limit1;
    logic [LIMIT_W-1:0] limit2;
    logic [LIMIT_W-1:0] low_limit;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic set_acc;
    logic step;
  } mac_ctl_t;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctl_t;

  // code * 18 * scale * 2^F, the dividend of the raw lux division
  function automatic logic [NUM_W-1:0] raw_numerator(input logic [CODE_W-1:0] code,
                                                     input logic [STAGE_W-1:0] stage);
    logic [CODE18_W-1:0] c18;
    logic [NUM_W-1:0]    base;
    c18  = CODE18_W'({code, 4'b0}) + CODE18_W'({code, 1'b0});
    base = NUM_W'(c18) << FRACTION_BITS;
    case (stage)
      STAGE_X2:      raw_numerator = base;
      STAGE_X1:      raw_numerator = base << 1;
      STAGE_QUARTER: raw_numerator = base << 3;
      default:       raw_numerator = base << 4;
    endcase
  endfunction

endpackage

// ----- design/light_sensor_autorange_lux_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// light_sensor_autorange_lux_core
// Auto-ranging lux converter: raw light counts in, gain requests or lux out.
// ----------------------------------------------------------------------------
// Readings enter on the meas channel (new_measurement, raw_code) and one
// result per reading leaves on the res channel. A result either asks for the
// next gain stage (switch_request, gain_stage_out) or carries the corrected
// lux, clipped to 65535 with lux_saturated.
// One reading at a time. A reading passes the serial raw-lux division
// (24 steps), then, unless a gain switch is requested, the serial
// multiply-accumulate (9, or 23 + 5 + 15 steps) and, unless the result
// saturates, the serial 16-step lux division; the block takes the next
// reading once the result has moved into the output register.
// The finished result sits in an output register, so a new reading is taken
// while it waits; a stalled receiver holds the next result in its final
// state until the register frees. Reset sets the gain stage to x2, restores
// the default limits and drops res_valid. Limits are to be written by the
// user over the APB port only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module light_sensor_autorange_lux_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lslux_pkg::ADDR_W-1:0]     paddr,
  input  logic [lslux_pkg::DATA_W-1:0]     pwdata,
  output logic [lslux_pkg::DATA_W-1:0]     prdata,
  output logic                             pready,
  input  logic                             meas_valid,
  output logic                             meas_ready,
  input  logic                             new_measurement,
  input  logic [lslux_pkg::CODE_W-1:0]     raw_code,
  output logic                             res_valid,
  input  logic                             res_ready,
  output logic                             switch_request,
  output logic [lslux_pkg::STAGE_W-1:0]    gain_stage_out,
  output logic [lslux_pkg::LUX_W-1:0]      lux_value,
  output logic                             lux_saturated
);
  import lslux_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RAW   = 4'd1;
  localparam logic [3:0] S_CHECK = 4'd2;
  localparam logic [3:0] S_LIN   = 4'd3;
  localparam logic [3:0] S_SQ    = 4'd4;
  localparam logic [3:0] S_LD29  = 4'd5;
  localparam logic [3:0] S_SQ29  = 4'd6;
  localparam logic [3:0] S_LDLT  = 4'd7;
  localparam logic [3:0] S_LT    = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;
  localparam logic [3:0] S_LUX   = 4'd10;
  localparam logic [3:0] S_GRAB  = 4'd11;
  localparam logic [3:0] S_PUT   = 4'd12;

  cfg_t                cfg;
  logic [3:0]          state;
  logic [CNT_W-1:0]    cnt;
  logic [STAGE_W-1:0]  gain_stage;
  logic [STAGE_W-1:0]  stage_use;
  logic [STAGE_W-1:0]  meas_stage;
  logic [RAW_W-1:0]    raw_q;
  logic                lin_sel;
  logic                res_switch;
  logic [STAGE_W-1:0]  res_stage;
  logic [LUX_W-1:0]    res_lux;
  logic                res_sat;

  logic                accept;
  logic                last_step;
  logic                out_load;
  logic [NUM_W-1:0]    num;
  logic [RAW_W-1:0]    raw_now;
  logic [LIMIT_W-1:0]  stage_limit;
  logic                over;
  logic                low;
  logic [Q_W-1:0]      q_val;
  logic [Q_W-17:0]     q_hi;
  logic [REM_W-1:0]    divisor_sel;
  logic                sat;

  mac_ctl_t            mac_ctl;
  logic [ACC_W-1:0]    mac_mcand;
  logic [RAW_W-1:0]    mac_mplier;
  logic [ACC_W-1:0]    mac_acc_in;
  logic [ACC_W-1:0]    acc;

  div_ctl_t            div_ctl;
  logic [REM_W-1:0]    div_rem;
  logic [DVD_W-1:0]    div_dvd;
  logic [REM_W-1:0]    div_divisor;
  logic [DVD_W-1:0]    div_quo;

  lslux_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lslux_smac u_mac (
    .clk       (clk),
    .ctl       (mac_ctl),
    .mcand_in  (mac_mcand),
    .mplier_in (mac_mplier),
    .acc_in    (mac_acc_in),
    .acc       (acc)
  );

  lslux_sdiv u_div (
    .clk        (clk),
    .ctl        (div_ctl),
    .rem_in     (div_rem),
    .dvd_in     (div_dvd),
    .divisor_in (div_divisor),
    .quo        (div_quo)
  );

  assign meas_ready = (state == S_IDLE);
  assign accept     = meas_valid & meas_ready;
  assign meas_stage = new_measurement ? STAGE_X2 : gain_stage;
  assign num        = raw_numerator(raw_code, meas_stage);
  assign last_step  = (cnt == CNT_W'(1));
  assign out_load   = (state == S_PUT) && (!res_valid || res_ready);

  assign raw_now = div_quo[RAW_W-1:0];

  always_comb begin
    case (stage_use)
      STAGE_X2: stage_limit = cfg.limit0;
      STAGE_X1: stage_limit = cfg.limit1;
      default:  stage_limit = cfg.limit2;
    endcase
  end

  assign over = (stage_use != STAGE_EIGHTH) &&
                (DVD_W'(raw_now) > {stage_limit, {FRACTION_BITS{1'b0}}});
  assign low  = DVD_W'(raw_now) < {cfg.low_limit, {FRACTION_BITS{1'b0}}};

  assign q_val       = acc[ACC_W-1:FRACTION_BITS];
  assign q_hi        = q_val[Q_W-1:LUX_W];
  assign divisor_sel = lin_sel ? DIV_LIN : DIV_QUAD;
  assign sat         = q_hi >= (Q_W-16)'(divisor_sel);

  // divider: raw lux on acceptance, lux after the accumulate
  always_comb begin
    div_ctl.load = accept || ((state == S_FIN) && !sat);
    div_ctl.step = (state == S_RAW) || (state == S_LUX);
    if (accept) begin
      div_rem     = REM_W'(num[NUM_W-1 -: DIV1_TOP_W]);
      div_dvd     = num[DVD_W-1:0];
      div_divisor = DIV_RAW;
    end else begin
      div_rem     = q_hi[REM_W-1:0];
      div_dvd     = {q_val[LUX_W-1:0], {FRACTION_BITS{1'b0}}};
      div_divisor = divisor_sel;
    end
  end

  // multiply-accumulate operand selection
  always_comb begin
    mac_ctl.load    = 1'b0;
    mac_ctl.set_acc = 1'b0;
    mac_ctl.step    = (state == S_LIN) || (state == S_SQ) ||
                      (state == S_SQ29) || (state == S_LT);
    mac_mcand       = ACC_W'(raw_q);
    mac_mplier      = K_LT;
    mac_acc_in      = '0;
    unique case (state)
      S_CHECK: begin
        mac_ctl.load    = !over;
        mac_ctl.set_acc = 1'b1;
        mac_mcand       = ACC_W'(raw_now);
        mac_mplier      = low ? K_LIN : raw_now;
      end
      S_LD29: begin
        mac_ctl.load    = 1'b1;
        mac_ctl.set_acc = 1'b1;
        mac_mcand       = ACC_W'(q_val);
        mac_mplier      = K_SQ;
        mac_acc_in      = QUAD_BIAS;
      end
      S_LDLT: begin
        mac_ctl.load    = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      gain_stage <= STAGE_X2;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            stage_use  <= meas_stage;
            gain_stage <= meas_stage;
            cnt        <= STEPS_RAW;
            state      <= S_RAW;
          end
        end
        S_RAW: begin
          cnt <= cnt - CNT_W'(1);
          if (last_step) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          raw_q <= raw_now;
          if (over) begin
            gain_stage <= stage_use + STAGE_W'(1);
            res_switch <= 1'b1;
            res_stage  <= stage_use + STAGE_W'(1);
            res_lux    <= '0;
            res_sat    <= 1'b0;
            state      <= S_PUT;
          end else begin
            res_switch <= 1'b0;
            res_stage  <= stage_use;
            lin_sel    <= low;
            cnt        <= low ? STEPS_LIN : STEPS_SQ;
            state      <= low ? S_LIN : S_SQ;
          end
        end
        S_LIN: begin
          cnt <= cnt - CNT_W'(1);
          if (last_step) begin
            state <= S_FIN;
          end
        end
        S_SQ: begin
          cnt <= cnt - CNT_W'(1);
          if (last_step) begin
            state <= S_LD29;
          end
        end
        S_LD29: begin
          cnt   <= STEPS_29;
          state <= S_SQ29;
        end
        S_SQ29: begin
          cnt <= cnt - CNT_W'(1);
          if (last_step) begin
            state <= S_LDLT;
          end
        end
        S_LDLT: begin
          cnt   <= STEPS_LT;
          state <= S_LT;
        end
        S_LT: begin
          cnt <= cnt - CNT_W'(1);
          if (last_step) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (sat) begin
            res_lux <= '1;
            res_sat <= 1'b1;
            state   <= S_PUT;
          end else begin
            res_sat <= 1'b0;
            cnt     <= STEPS_LUX;
            state   <= S_LUX;
          end
        end
        S_LUX: begin
          cnt <= cnt - CNT_W'(1);
          if (last_step) begin
            state <= S_GRAB;
          end
        end
        S_GRAB: begin
          res_lux <= div_quo[LUX_W-1:0];
          state   <= S_PUT;
        end
        S_PUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      switch_request <= res_switch;
      gain_stage_out <= res_stage;
      lux_value      <= res_lux;
      lux_saturated  <= res_sat;
    end
  end

endmodule

// ----- design/lslux_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lslux_regs
// APB register bank holding the stage limits and the low-light limit.
// ----------------------------------------------------------------------------
module lslux_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lslux_pkg::ADDR_W-1:0]   paddr,
  input  logic [lslux_pkg::DATA_W-1:0]   pwdata,
  output logic [lslux_pkg::DATA_W-1:0]   prdata,
  output logic                           pready,
  output lslux_pkg::cfg_t                cfg
);
  import lslux_pkg::*;

  logic                 wr_en;
  logic [REG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.limit0    <= LIMIT_W'(1880);
      cfg.limit1    <= LIMIT_W'(3760);
      cfg.limit2    <= LIMIT_W'(15000);
      cfg.low_limit <= LIMIT_W'(30);
    end else if (wr_en) begin
      unique case (idx)
        REG_LIMIT0: cfg.limit0    <= pwdata[LIMIT_W-1:0];
        REG_LIMIT1: cfg.limit1    <= pwdata[LIMIT_W-1:0];
        REG_LIMIT2: cfg.limit2    <= pwdata[LIMIT_W-1:0];
        REG_LOW:    cfg.low_limit <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_LIMIT0: prdata = DATA_W'(cfg.limit0);
      REG_LIMIT1: prdata = DATA_W'(cfg.limit1);
      REG_LIMIT2: prdata = DATA_W'(cfg.limit2);
      REG_LOW:    prdata = DATA_W'(cfg.low_limit);
      default:    prdata = '0;
    endcase
  end

endmodule

// ----- design/lslux_smac.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lslux_smac
// Bit-serial shift-and-add multiply-accumulate, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module lslux_smac (
  input  logic                          clk,
  input  lslux_pkg::mac_ctl_t           ctl,
  input  logic [lslux_pkg::ACC_W-1:0]   mcand_in,
  input  logic [lslux_pkg::RAW_W-1:0]   mplier_in,
  input  logic [lslux_pkg::ACC_W-1:0]   acc_in,
  output logic [lslux_pkg::ACC_W-1:0]   acc
);
  import lslux_pkg::*;

  logic [ACC_W-1:0] mcand;
  logic [RAW_W-1:0] mplier;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      mcand  <= mcand_in;
      mplier <= mplier_in;
      if (ctl.set_acc) begin
        acc <= acc_in;
      end
    end else if (ctl.step) begin
      if (mplier[0]) begin
        acc <= acc + mcand;
      end
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
    end
  end

endmodule

// ----- design/lslux_sdiv.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lslux_sdiv
// Restoring divider, one quotient bit per cycle, dividend shifted in msb first.
// ----------------------------------------------------------------------------
module lslux_sdiv (
  input  logic                          clk,
  input  lslux_pkg::div_ctl_t           ctl,
  input  logic [lslux_pkg::REM_W-1:0]   rem_in,
  input  logic [lslux_pkg::DVD_W-1:0]   dvd_in,
  input  logic [lslux_pkg::REM_W-1:0]   divisor_in,
  output logic [lslux_pkg::DVD_W-1:0]   quo
);
  import lslux_pkg::*;

  logic [REM_W-1:0] rem;
  logic [DVD_W-1:0] dvd;
  logic [REM_W-1:0] divisor;
  logic [REM_W:0]   trial;
  logic [REM_W:0]   diff;
  logic             fits;

  assign trial = {rem, dvd[DVD_W-1]};
  assign fits  = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rem     <= rem_in;
      dvd     <= dvd_in;
      divisor <= divisor_in;
      quo     <= '0;
    end else if (ctl.step) begin
      rem <= fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
      dvd <= dvd << 1;
      quo <= {quo[DVD_W-2:0], fits};
    end
  end

endmodule

// ----- design/lslux_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lslux_checker
// Port-level checks for the auto-ranging lux converter, bound to the top level.
// ----------------------------------------------------------------------------
module lslux_checker (
  input logic        clk,
  input logic        rst,
  input logic        meas_valid,
  input logic        meas_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic        switch_request,
  input logic [1:0]  gain_stage_out,
  input logic [15:0] lux_value,
  input logic        lux_saturated
);
  import lslux_pkg::*;

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(lux_value) &&
      $stable(switch_request) && $stable(gain_stage_out) && $stable(lux_saturated))
    else $error("stalled result changed");

  // one reading in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    meas_valid && meas_ready |=> !meas_ready)
    else $error("reading taken while busy");

  // a gain request carries no lux
  a_switch_empty: assert property (@(posedge clk) disable iff (rst)
    res_valid && switch_request |-> lux_value == 16'd0 && !lux_saturated)
    else $error("gain request with lux data");

  // a gain request never points back to stage x2
  a_switch_stage: assert property (@(posedge clk) disable iff (rst)
    res_valid && switch_request |-> gain_stage_out != STAGE_X2)
    else $error("gain request to first stage");

  // clipping gives full scale
  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    res_valid && lux_saturated |-> lux_value == 16'hFFFF)
    else $error("saturated lux not full scale");

endmodule

bind light_sensor_autorange_lux_core lslux_checker u_checker (.*);

// ----- tb/light_sensor_autorange_lux_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// light_sensor_autorange_lux_core_tb
// Self-checking bench for the auto-ranging lux converter core.
// ----------------------------------------------------------------------------
// A directed table walks the gain stages to the last one, the saturation
// corner, the low-light boundary and the stage-limit boundary. Random
// measurement sequences follow under six limit settings, all-zero and
// all-ones among them, with three sender/receiver idle patterns, a long
// receiver stall and a drain between settings. Each result transaction is
// compared field by field against an in-bench integer model of the
// conversion and of the gain stage. Limits are read back over APB.
// ----------------------------------------------------------------------------
module light_sensor_autorange_lux_core_tb;
  import lslux_pkg::*;

  typedef struct packed {
    logic               sw;
    logic [STAGE_W-1:0] stage;
    logic [LUX_W-1:0]   lux;
    logic               sat;
  } lux_result_t;

  typedef struct packed {
    logic              nm;
    logic [CODE_W-1:0] code;
    logic              known;
    lux_result_t       res;
  } reading_row_t;

  localparam int N_DIRECTED     = 20;
  localparam int N_PHASES       = 6;
  localparam int READINGS_PHASE = 67;
  localparam int HOLD_CYCLES    = 500;

  // known rows assume the reset limits and start at stage x2
  localparam reading_row_t DIRECTED [N_DIRECTED] = '{
    {1'b1, 16'd0,     1'b1, 1'b0, STAGE_X2,      16'd0,     1'b0},
    {1'b1, 16'd65535, 1'b1, 1'b1, STAGE_X1,      16'd0,     1'b0},
    {1'b0, 16'd65535, 1'b1, 1'b1, STAGE_QUARTER, 16'd0,     1'b0},
    {1'b0, 16'd65535, 1'b1, 1'b1, STAGE_EIGHTH,  16'd0,     1'b0},
    {1'b0, 16'd65535, 1'b1, 1'b0, STAGE_EIGHTH,  16'd65535, 1'b1},
    {1'b0, 16'd0,     1'b1, 1'b0, STAGE_EIGHTH,  16'd0,     1'b0},
    {1'b0, 16'd1,     1'b0, 20'd0},
    {1'b1, 16'd1,     1'b0, 20'd0},
    {1'b1, 16'd1041,  1'b0, 20'd0},
    {1'b1, 16'd1042,  1'b0, 20'd0},
    {1'b1, 16'd65277, 1'b0, 20'd0},
    {1'b1, 16'd65278, 1'b0, 20'd0},
    {1'b0, 16'd32768, 1'b0, 20'd0},
    {1'b0, 16'd21845, 1'b0, 20'd0},
    {1'b1, 16'd43690, 1'b0, 20'd0},
    {1'b0, 16'd65535, 1'b0, 20'd0},
    {1'b0, 16'd65535, 1'b0, 20'd0},
    {1'b0, 16'd1000,  1'b0, 20'd0},
    {1'b1, 16'd32767, 1'b0, 20'd0},
    {1'b1, 16'd1,     1'b0, 20'd0}
  };

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                meas_valid = 1'b0;
  logic                meas_ready;
  logic                new_measurement = 1'b0;
  logic [CODE_W-1:0]   raw_code = '0;
  logic                res_valid;
  logic                res_ready = 1'b0;
  logic                switch_request;
  logic [STAGE_W-1:0]  gain_stage_out;
  logic [LUX_W-1:0]    lux_value;
  logic                lux_saturated;

  logic [LIMIT_W-1:0]  model_limits [4];
  logic [STAGE_W-1:0]  model_stage;
  logic                model_switch_pending;
  lux_result_t         lux_results_due [$];

  int  send_idle_pct = 25;
  int  recv_idle_pct = 80;
  logic holding = 1'b0;
  event hold_off_ev;

  int err_count = 0;
  int readings_sent = 0;
  int results_checked = 0;
  int switches_seen = 0;
  int saturated_seen = 0;

  light_sensor_autorange_lux_core u_dut (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .meas_valid      (meas_valid),
    .meas_ready      (meas_ready),
    .new_measurement (new_measurement),
    .raw_code        (raw_code),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .switch_request  (switch_request),
    .gain_stage_out  (gain_stage_out),
    .lux_value       (lux_value),
    .lux_saturated   (lux_saturated)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic lux_result_t convert_reading(input logic nm,
                                                  input logic [CODE_W-1:0] code);
    lux_result_t        res;
    logic [63:0]        one;
    logic [63:0]        raw;
    logic [63:0]        lux;
    logic [63:0]        sq;
    logic [63:0]        scale;
    logic [63:0]        limit;
    logic [STAGE_W-1:0] stage;
    one = 64'd1 << FRACTION_BITS;
    if (nm) model_stage = STAGE_X2;
    stage = model_stage;
    case (stage)
      STAGE_X2: begin
        scale = 64'd1;
        limit = 64'(model_limits[REG_LIMIT0]);
      end
      STAGE_X1: begin
        scale = 64'd2;
        limit = 64'(model_limits[REG_LIMIT1]);
      end
      STAGE_QUARTER: begin
        scale = 64'd8;
        limit = 64'(model_limits[REG_LIMIT2]);
      end
      default: begin
        scale = 64'd16;
        limit = 64'd0;
      end
    endcase
    raw = (64'(code) * 64'd18 * scale * one) / 64'd625;
    res = '0;
    res.stage = stage;
    model_switch_pending = 1'b0;
    if (stage != STAGE_EIGHTH && raw > (limit << FRACTION_BITS)) begin
      model_stage = stage + 1'b1;
      model_switch_pending = 1'b1;
      res.sw = 1'b1;
      res.stage = model_stage;
      return res;
    end
    if (raw < (64'(model_limits[REG_LOW]) << FRACTION_BITS)) begin
      lux = (raw * 64'd283) / (64'd100 * one);
    end else begin
      sq  = (raw * raw) >> FRACTION_BITS;
      lux = (sq * 64'd29 + raw * 64'd22112 + 64'd185227 * one) / (64'd10000 * one);
    end
    if (lux > 64'd65535) begin
      res.lux = '1;
      res.sat = 1'b1;
    end else begin
      res.lux = lux[LUX_W-1:0];
    end
    return res;
  endfunction

  // mostly well-formed sequences: a re-read follows each gain switch
  function automatic reading_row_t random_reading();
    reading_row_t row;
    row = '0;
    if (model_switch_pending) row.nm = ($urandom_range(9) == 0);
    else row.nm = ($urandom_range(99) < 85);
    case ($urandom_range(7))
      0, 1:    row.code = CODE_W'($urandom_range(2000));
      2:       row.code = CODE_W'($urandom_range(65535, 60000));
      default: row.code = CODE_W'($urandom());
    endcase
    return row;
  endfunction

  task automatic offer_reading(input reading_row_t row);
    lux_result_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      meas_valid <= 1'b0;
      @(posedge clk);
    end
    meas_valid      <= 1'b1;
    new_measurement <= row.nm;
    raw_code        <= row.code;
    do @(posedge clk); while (!meas_ready);
    pred = convert_reading(row.nm, row.code);
    lux_results_due.push_back(row.known ? row.res : pred);
    readings_sent++;
  endtask

  task automatic drain_results();
    meas_valid <= 1'b0;
    while (lux_results_due.size() != 0) @(posedge clk);
  endtask

  // write, then read back over the same select
  task automatic write_limit(input logic [REG_IDX_W-1:0] idx,
                             input logic [LIMIT_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= DATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    model_limits[idx] = val;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== DATA_W'(val)) begin
      $error("prdata: expected %0d, actual %0d", val, prdata);
      err_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst || holding) res_ready <= 1'b0;
    else res_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always begin
    @(hold_off_ev);
    holding <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    holding <= 1'b0;
  end

  always @(posedge clk) begin : check_results
    lux_result_t want;
    if (!rst && res_valid && res_ready) begin
      if (lux_results_due.size() == 0) begin
        $error("result transaction with nothing expected");
        err_count++;
      end else begin
        want = lux_results_due.pop_front();
        results_checked++;
        if (switch_request) switches_seen++;
        if (lux_saturated) saturated_seen++;
        if (switch_request !== want.sw) begin
          $error("switch_request: expected %0d, actual %0d", want.sw, switch_request);
          err_count++;
        end
        if (gain_stage_out !== want.stage) begin
          $error("gain_stage_out: expected %0d, actual %0d", want.stage, gain_stage_out);
          err_count++;
        end
        if (lux_value !== want.lux) begin
          $error("lux_value: expected %0d, actual %0d", want.lux, lux_value);
          err_count++;
        end
        if (lux_saturated !== want.sat) begin
          $error("lux_saturated: expected %0d, actual %0d", want.sat, lux_saturated);
          err_count++;
        end
      end
    end
  end

  initial begin : stimulus
    logic [LIMIT_W-1:0] lim [4];
    model_limits[REG_LIMIT0] = 16'd1880;
    model_limits[REG_LIMIT1] = 16'd3760;
    model_limits[REG_LIMIT2] = 16'd15000;
    model_limits[REG_LOW]    = 16'd30;
    model_stage = STAGE_X2;
    model_switch_pending = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) offer_reading(DIRECTED[i]);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain_results();
      send_idle_pct = (ph < 2) ? 25 : (ph < 4) ? 80 : 0;
      recv_idle_pct = (ph < 2) ? 80 : (ph < 4) ? 25 : 0;
      case (ph)
        0: lim = '{16'd1880, 16'd3760, 16'd15000, 16'd30};
        1: lim = '{16'd0, 16'd0, 16'd0, 16'd0};
        2: lim = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        4: lim = '{LIMIT_W'($urandom_range(2000)), LIMIT_W'($urandom_range(4000)),
                   LIMIT_W'($urandom_range(16000)), LIMIT_W'($urandom_range(100))};
        default: lim = '{LIMIT_W'($urandom()), LIMIT_W'($urandom()),
                         LIMIT_W'($urandom()), LIMIT_W'($urandom_range(5000))};
      endcase
      write_limit(REG_LIMIT0, lim[0]);
      write_limit(REG_LIMIT1, lim[1]);
      write_limit(REG_LIMIT2, lim[2]);
      write_limit(REG_LOW, lim[3]);
      @(posedge clk);
      // long receiver stall while readings keep coming
      if (ph == 4) -> hold_off_ev;
      for (int k = 0; k < READINGS_PHASE; k++) offer_reading(random_reading());
    end

    drain_results();
    repeat (100) @(posedge clk);
    $display("covered %0d readings, %0d results checked, %0d gain switches, %0d saturated",
             readings_sent, results_checked, switches_seen, saturated_seen);
    $display("six limit settings incl. all-zero and all-ones, three idle mixes, long stall");
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/lslux_pkg.sv
design/lslux_regs.sv
design/lslux_smac.sv
design/lslux_sdiv.sv
design/light_sensor_autorange_lux_core.sv
design/lslux_checker.sv
tb/light_sensor_autorange_lux_core_tb.sv
